[src/dual_axis_guide_pulse_sequencer_unit_assert.svh]
// ----------------------------------------------------------------------------
// dual axis guide pulse sequencer assertion macros
// immediate-implication and next-cycle checks on the block clock
// ----------------------------------------------------------------------------
`ifndef DUAL_AXIS_GUIDE_PULSE_SEQUENCER_UNIT_ASSERT_SVH
`define DUAL_AXIS_GUIDE_PULSE_SEQUENCER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DAGPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dagps check failed");

// antecedent implies consequent in the next cycle
`define DAGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dagps check failed");

`endif

[src/dagps_pkg.sv]
// ----------------------------------------------------------------------------
// dagps_pkg
// codes, reset values and result type of the guide pulse sequencer
// ----------------------------------------------------------------------------
package dagps_pkg;

    localparam logic [1:0] CMD_GUIDE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;

    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_POLL_WAIT  = 1'b1;

    localparam logic [7:0] POLL_LIMIT_RST = 8'd50;
    localparam logic [7:0] POLL_WAIT_RST  = 8'd10;

    localparam logic [7:0] CODE_QUERY    = 8'hA2;
    localparam logic [7:0] CODE_LEFT_ON  = 8'hA8;
    localparam logic [7:0] CODE_RIGHT_ON = 8'hAA;
    localparam logic [7:0] CODE_DOWN_ON  = 8'hA6;
    localparam logic [7:0] CODE_UP_ON    = 8'hA4;
    localparam logic [7:0] CODE_LEFT_OFF = 8'hA9;
    localparam logic [7:0] CODE_RIGHT_OFF = 8'hAB;
    localparam logic [7:0] CODE_DOWN_OFF = 8'hA7;
    localparam logic [7:0] CODE_UP_OFF   = 8'hA5;

    localparam int PULSE_W = 16;
    localparam int MAG_W   = PULSE_W + 1;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       skipped;
        logic       guide_done;
        logic       last_of_run;
    } t_res;

    function automatic t_res mk_res(input logic v, input logic [7:0] b,
                                    input logic s, input logic d);
        t_res r;
        r.tx_valid    = v;
        r.tx_byte     = b;
        r.skipped     = s;
        r.guide_done  = d;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

[src/dual_axis_guide_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// dual_axis_guide_pulse_sequencer_unit
// turns signed ra/de pulse requests, ms ticks and reply bytes into key codes
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata ra,de,rx  tuser command
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata tx_byte   tuser flags, tlast
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// items pass through a single next-state stage into a two-entry result buffer;
// an item that yields two results blocks input until the first of them is taken
// and the second result drains; the buffer is the only source of stall
// synchronous active-low reset clears state, config to 50 polls and 10 ticks
// ----------------------------------------------------------------------------
module dual_axis_guide_pulse_sequencer_unit #(
    parameter int DURATION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // ra_pulse, de_pulse, rx_byte
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tx_byte
    output logic [2:0]  m_axis_tuser,   // tx_valid, skipped, guide_done
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CW   = DURATION_BITS;
    localparam int MW   = dagps_pkg::MAG_W;
    localparam int SW   = (CW > MW) ? CW : MW;
    localparam logic [SW-1:0] DUR_MAX = {{(SW-CW){1'b0}}, {CW{1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE, S_START_RA, S_START_DE, S_PHASE1,
        S_REL_SHORT, S_PHASE2, S_REL_DE, S_REL_RA
    } t_step;

    t_step           r_step, n_step;
    logic            r_awaiting, n_awaiting;
    logic            r_ra_right, n_ra_right;
    logic            r_de_up, n_de_up;
    logic            r_ra_shorter, n_ra_shorter;
    logic [CW-1:0]   r_first, n_first;
    logic [CW-1:0]   r_second, n_second;
    logic [CW-1:0]   r_wait, n_wait;
    logic [7:0]      r_failed, n_failed;
    logic            r_ra_started, n_ra_started;
    logic            r_de_started, n_de_started;
    logic [7:0]      r_poll_limit;
    logic [7:0]      r_poll_wait;
    logic [1:0]      r_cnt, n_cnt;
    dagps_pkg::t_res r_slot0, r_slot1;
    dagps_pkg::t_res res_a, res_b;

    logic            acc, pop;
    logic [15:0]     ra_raw, de_raw;
    logic [SW-1:0]   ra_mag, de_mag;
    logic [CW-1:0]   ra_sat, de_sat;
    logic [CW-1:0]   wait_dec;
    logic            is_cmd;
    logic [7:0]      code;
    logic            do_run, do_fin, do_query, do_wait;
    t_step           run_s;

    assign pop           = (r_cnt != 2'd0) && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_slot0.tx_byte;
    assign m_axis_tuser  = {r_slot0.guide_done, r_slot0.skipped, r_slot0.tx_valid};
    assign m_axis_tlast  = r_slot0.last_of_run;

    assign ra_raw = s_axis_tdata[15:0];
    assign de_raw = s_axis_tdata[31:16];

    always_comb begin
        logic [MW-1:0] ra_m, de_m;
        ra_m = ra_raw[15] ? (MW'(17'h10000) - MW'(ra_raw)) : MW'(ra_raw);
        de_m = de_raw[15] ? (MW'(17'h10000) - MW'(de_raw)) : MW'(de_raw);
        ra_mag = SW'(ra_m);
        de_mag = SW'(de_m);
        ra_sat = (ra_mag > DUR_MAX) ? DUR_MAX[CW-1:0] : ra_mag[CW-1:0];
        de_sat = (de_mag > DUR_MAX) ? DUR_MAX[CW-1:0] : de_mag[CW-1:0];
    end

    assign wait_dec = (r_wait != '0) ? (r_wait - CW'(1)) : r_wait;
    assign is_cmd   = (r_step inside {S_START_RA, S_START_DE, S_REL_SHORT, S_REL_DE,
                                      S_REL_RA});

    always_comb begin
        logic [7:0] ra_off, de_off;
        ra_off = r_ra_right ? dagps_pkg::CODE_RIGHT_OFF : dagps_pkg::CODE_LEFT_OFF;
        de_off = r_de_up ? dagps_pkg::CODE_UP_OFF : dagps_pkg::CODE_DOWN_OFF;
        case (r_step)
            S_START_RA:  code = r_ra_right ? dagps_pkg::CODE_RIGHT_ON
                                           : dagps_pkg::CODE_LEFT_ON;
            S_START_DE:  code = r_de_up ? dagps_pkg::CODE_UP_ON : dagps_pkg::CODE_DOWN_ON;
            S_REL_SHORT: code = r_ra_shorter ? ra_off : de_off;
            S_REL_DE:    code = de_off;
            default:     code = ra_off;
        endcase
    end

    always_comb begin
        logic      has_a, has_b;
        t_step     s;
        n_step       = r_step;
        n_awaiting   = r_awaiting;
        n_ra_right   = r_ra_right;
        n_de_up      = r_de_up;
        n_ra_shorter = r_ra_shorter;
        n_first      = r_first;
        n_second     = r_second;
        n_wait       = r_wait;
        n_failed     = r_failed;
        n_ra_started = r_ra_started;
        n_de_started = r_de_started;
        res_a        = dagps_pkg::mk_res(1'b0, 8'd0, 1'b0, 1'b0);
        res_b        = res_a;
        has_a        = 1'b0;
        has_b        = 1'b0;
        do_run       = 1'b0;
        do_fin       = 1'b0;
        do_query     = 1'b0;
        do_wait      = 1'b0;
        run_s        = S_IDLE;
        s            = S_IDLE;

        // first part: decode the item, at most one result before the run
        if (acc) begin
            case (s_axis_tuser)
                dagps_pkg::CMD_GUIDE: begin
                    if (r_step == S_IDLE) begin
                        if ((ra_raw == 16'd0) && (de_raw == 16'd0)) begin
                            res_a = dagps_pkg::mk_res(1'b0, 8'd0, 1'b0, 1'b1);
                            has_a = 1'b1;
                        end else begin
                            n_ra_started = (ra_raw != 16'd0);
                            n_de_started = (de_raw != 16'd0);
                            n_ra_right   = (ra_raw != 16'd0) && ra_raw[15];
                            n_de_up      = (de_raw != 16'd0) && de_raw[15];
                            if (ra_sat > de_sat) begin
                                n_ra_shorter = 1'b0;
                                n_first      = de_sat;
                                n_second     = ra_sat - de_sat;
                            end else begin
                                n_ra_shorter = 1'b1;
                                n_first      = ra_sat;
                                n_second     = de_sat - ra_sat;
                            end
                            n_awaiting = 1'b0;
                            n_wait     = '0;
                            do_run     = 1'b1;
                            run_s      = S_START_RA;
                        end
                    end
                end
                dagps_pkg::CMD_TICK: begin
                    if ((r_step == S_PHASE1) || (r_step == S_PHASE2)) begin
                        n_wait = wait_dec;
                        if (wait_dec == '0) begin
                            do_run = 1'b1;
                            run_s  = (r_step == S_PHASE1) ? S_REL_SHORT : S_REL_DE;
                        end
                    end else if (is_cmd && !r_awaiting) begin
                        n_wait = wait_dec;
                        if (wait_dec == '0) begin
                            n_awaiting = 1'b1;
                            res_a      = dagps_pkg::mk_res(1'b1, dagps_pkg::CODE_QUERY,
                                                           1'b0, 1'b0);
                            has_a      = 1'b1;
                        end
                    end
                end
                dagps_pkg::CMD_REPLY: begin
                    if (is_cmd && r_awaiting) begin
                        if ((r_failed >= r_poll_limit) || (s_axis_tdata[39:32] == 8'd0)) begin
                            if (r_failed >= r_poll_limit) begin
                                res_a = dagps_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b0);
                            end else begin
                                res_a = dagps_pkg::mk_res(1'b1, code, 1'b0, 1'b0);
                            end
                            has_a      = 1'b1;
                            n_awaiting = 1'b0;
                            n_wait     = '0;
                            do_run     = 1'b1;
                            case (r_step)
                                S_START_RA:  run_s = S_START_DE;
                                S_START_DE:  run_s = S_PHASE1;
                                S_REL_SHORT: run_s = S_PHASE2;
                                S_REL_DE:    run_s = S_REL_RA;
                                default:     do_fin = 1'b1;
                            endcase
                        end else begin
                            n_failed   = r_failed + 8'd1;
                            n_awaiting = 1'b0;
                            n_wait     = CW'(r_poll_wait);
                            if (r_poll_wait == 8'd0) begin
                                n_awaiting = 1'b1;
                                n_wait     = '0;
                                res_a      = dagps_pkg::mk_res(1'b1, dagps_pkg::CODE_QUERY,
                                                               1'b0, 1'b0);
                                has_a      = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // second part: advance the sequence until it needs a tick or a reply, or finish the run
        if (do_run) begin
            if (do_fin) begin
                n_step = S_IDLE;
                res_b  = dagps_pkg::mk_res(1'b0, 8'd0, 1'b0, 1'b1);
                has_b  = 1'b1;
            end else begin
                s = run_s;
                if (s == S_START_RA) begin
                    if (n_ra_started) do_query = 1'b1;
                    else s = S_START_DE;
                end
                if (!do_query && (s == S_START_DE)) begin
                    if (n_de_started) do_query = 1'b1;
                    else s = S_PHASE1;
                end
                if (!do_query && (s == S_PHASE1)) begin
                    if (n_first != '0) do_wait = 1'b1;
                    else s = S_PHASE2;
                end
                if (!do_query && !do_wait && (s == S_PHASE2)) begin
                    if (n_second != '0) do_wait = 1'b1;
                    else s = S_REL_DE;
                end
                if (!do_query && !do_wait) do_query = 1'b1;
                n_step = s;
                if (do_wait) begin
                    n_wait = (s == S_PHASE1) ? n_first : n_second;
                end
                if (do_query) begin
                    n_awaiting = 1'b1;
                    n_wait     = '0;
                    n_failed   = 8'd0;
                    res_b      = dagps_pkg::mk_res(1'b1, dagps_pkg::CODE_QUERY, 1'b0, 1'b0);
                    has_b      = 1'b1;
                end
            end
        end

        // pack results into the buffer order and mark the final one
        if (!has_a && has_b) begin
            res_a = res_b;
            has_a = 1'b1;
            has_b = 1'b0;
        end
        if (has_b) res_b.last_of_run = 1'b1;
        else if (has_a) res_a.last_of_run = 1'b1;

        if (acc) n_cnt = {has_b, has_a && !has_b};
        else if (pop) n_cnt = r_cnt - 2'd1;
        else n_cnt = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= S_IDLE;
            r_awaiting   <= 1'b0;
            r_ra_right   <= 1'b0;
            r_de_up      <= 1'b0;
            r_ra_shorter <= 1'b0;
            r_first      <= '0;
            r_second     <= '0;
            r_wait       <= '0;
            r_failed     <= 8'd0;
            r_ra_started <= 1'b0;
            r_de_started <= 1'b0;
            r_poll_limit <= dagps_pkg::POLL_LIMIT_RST;
            r_poll_wait  <= dagps_pkg::POLL_WAIT_RST;
            r_cnt        <= 2'd0;
        end else begin
            r_step       <= n_step;
            r_awaiting   <= n_awaiting;
            r_ra_right   <= n_ra_right;
            r_de_up      <= n_de_up;
            r_ra_shorter <= n_ra_shorter;
            r_first      <= n_first;
            r_second     <= n_second;
            r_wait       <= n_wait;
            r_failed     <= n_failed;
            r_ra_started <= n_ra_started;
            r_de_started <= n_de_started;
            r_cnt        <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dagps_pkg::CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                    dagps_pkg::CFG_POLL_WAIT:  r_poll_wait  <= i_cfg_data;
                endcase
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_slot0 <= res_a;
            r_slot1 <= res_b;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    `include "dual_axis_guide_pulse_sequencer_unit_assert.svh"

    `DAGPS_ASSERT_NOW(a_await_no_wait, i_clk, i_rst_n, r_awaiting, r_wait == '0)
    `DAGPS_ASSERT_NOW(a_idle_no_await, i_clk, i_rst_n, r_step == S_IDLE, !r_awaiting)
    `DAGPS_ASSERT_NOW(a_second_is_last, i_clk, i_rst_n, r_cnt == 2'd2,
                      r_slot1.last_of_run && !r_slot0.last_of_run)
    `DAGPS_ASSERT_NEXT(a_tick_idle_stays, i_clk, i_rst_n,
                       acc && (s_axis_tuser == dagps_pkg::CMD_TICK) && (r_step == S_IDLE),
                       r_step == S_IDLE)

endmodule
